// ===== sv/tcf_pkg.sv =====
// Shared types, constants and tables for the tilt complementary filter.
package tcf_pkg;

    localparam int unsigned AtanTabLen = 24;
    localparam int unsigned ZW = 32;   // CORDIC angle accumulator, 2^-24 degree

    function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 32'sd754974720;
            5'd1:    v = 32'sd445687602;
            5'd2:    v = 32'sd235489088;
            5'd3:    v = 32'sd119537938;
            5'd4:    v = 32'sd60000934;
            5'd5:    v = 32'sd30029717;
            5'd6:    v = 32'sd15018523;
            5'd7:    v = 32'sd7509720;
            5'd8:    v = 32'sd3754917;
            5'd9:    v = 32'sd1877466;
            5'd10:   v = 32'sd938734;
            5'd11:   v = 32'sd469367;
            5'd12:   v = 32'sd234684;
            5'd13:   v = 32'sd117342;
            5'd14:   v = 32'sd58671;
            5'd15:   v = 32'sd29335;
            5'd16:   v = 32'sd14668;
            5'd17:   v = 32'sd7334;
            5'd18:   v = 32'sd3667;
            5'd19:   v = 32'sd1833;
            5'd20:   v = 32'sd917;
            5'd21:   v = 32'sd458;
            5'd22:   v = 32'sd229;
            5'd23:   v = 32'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Datapath command from the controller.
    typedef struct packed {
        logic load;        // capture a new sample
        logic sq_start;    // start one square root (sel picks the axis pair)
        logic sel;         // 0: roll operands, 1: pitch operands
        logic sq_step;     // one square-root iteration
        logic cor_init;    // load CORDIC from root and numerator
        logic cor_step;    // one CORDIC iteration
        logic tilt_save;   // store the rounded tilt angle
        logic mul_en;      // one step of the shared multiply sequence
        logic [3:0] mul_op;
        logic commit;      // update angle state and output register
    } t_cmd;

    typedef struct packed {
        logic sq_done;
        logic cor_done;
    } t_sts;

    localparam logic [3:0] MulIncX = 4'd0;
    localparam logic [3:0] MulIncY = 4'd1;
    localparam logic [3:0] MulIncZ = 4'd2;
    localparam logic [3:0] MulRollG = 4'd3;
    localparam logic [3:0] MulRollT = 4'd4;
    localparam logic [3:0] MulPitchG = 4'd5;
    localparam logic [3:0] MulPitchT = 4'd6;

endpackage

// ===== sv/tcf_ctrl.sv =====
// Sequencer for the tilt filter: square roots, CORDIC runs and the multiply steps.
module tcf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output tcf_pkg::t_cmd  o_cmd,
    input  tcf_pkg::t_sts  i_sts
);
    import tcf_pkg::*;

    localparam logic [3:0] StIdle  = 4'd0;
    localparam logic [3:0] StSqS   = 4'd1;
    localparam logic [3:0] StSq    = 4'd2;
    localparam logic [3:0] StCorI  = 4'd3;
    localparam logic [3:0] StCor   = 4'd4;
    localparam logic [3:0] StSave  = 4'd5;
    localparam logic [3:0] StMul   = 4'd6;
    localparam logic [3:0] StDone  = 4'd7;
    localparam logic [3:0] StDrain = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_sel, n_sel;
    logic [3:0] r_op, n_op;
    logic       r_out_valid, n_out_valid;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        n_sel = r_sel;
        n_op = r_op;
        n_out_valid = r_out_valid;
        cmd = '0;
        cmd.sel = r_sel;
        cmd.mul_op = r_op;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            StIdle: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_sel = 1'b0;
                    n_state = StSqS;
                end
            end
            StSqS: begin
                cmd.sq_start = 1'b1;
                n_state = StSq;
            end
            StSq: begin
                cmd.sq_step = 1'b1;
                if (i_sts.sq_done) begin
                    n_state = StCorI;
                end
            end
            StCorI: begin
                cmd.cor_init = 1'b1;
                n_state = StCor;
            end
            StCor: begin
                cmd.cor_step = 1'b1;
                if (i_sts.cor_done) begin
                    n_state = StSave;
                end
            end
            StSave: begin
                cmd.tilt_save = 1'b1;
                if (r_sel) begin
                    n_op = MulIncX;
                    n_state = StMul;
                end else begin
                    n_sel = 1'b1;
                    n_state = StSqS;
                end
            end
            StMul: begin
                cmd.mul_en = 1'b1;
                if (r_op == MulPitchT) begin
                    n_state = StDrain;
                end else begin
                    n_op = r_op + 4'd1;
                end
            end
            // Let the last product land in the pitch angle.
            StDrain: begin
                n_state = StDone;
            end
            StDone: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.commit = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = StIdle;
                end
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_sel <= 1'b0;
            r_op <= MulIncX;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel <= n_sel;
            r_op <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall = (r_state != StIdle);
    assign o_out_valid = r_out_valid;
    assign o_cmd = cmd;
endmodule

// ===== sv/tcf_datapath.sv =====
// Datapath: square root, CORDIC, shared multiplier, blend and angle state.
module tcf_datapath #(
    parameter int unsigned CORDIC_STEPS    = 16,
    parameter int unsigned ANGLE_FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  tcf_pkg::t_cmd       i_cmd,
    output tcf_pkg::t_sts       o_sts,
    input  logic                i_rst_n,
    input  logic signed [15:0]  i_ax,
    input  logic signed [15:0]  i_ay,
    input  logic signed [15:0]  i_az,
    input  logic signed [15:0]  i_gx,
    input  logic signed [15:0]  i_gy,
    input  logic signed [15:0]  i_gz,
    input  logic [16:0]         i_blend_weight,
    input  logic [23:0]         i_gyro_gain,
    output logic signed [31:0]  o_roll,
    output logic signed [31:0]  o_pitch,
    output logic signed [31:0]  o_yaw
);
    import tcf_pkg::*;

    localparam int unsigned Steps = (CORDIC_STEPS > AtanTabLen) ? AtanTabLen : CORDIC_STEPS;
    localparam int unsigned CntW = 5;
    localparam int unsigned ZSh = 24 - ANGLE_FRAC_BITS;
    localparam int unsigned GSh = 32 - ANGLE_FRAC_BITS;
    localparam int unsigned XW = 40;  // CORDIC x/y width

    logic signed [15:0] r_ax, r_ay, r_az, r_gx, r_gy, r_gz;

    // Square root operand: a^2+b^2 <= 2^31; radicand (a^2+b^2)<<32, 32 result bits.
    logic [31:0] r_sq;      // a^2 + b^2
    logic [63:0] r_rem_n;   // radicand consumed two bits a step
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [CntW-1:0] r_cnt;
    logic signed [16:0] r_num;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic signed [31:0] r_tilt_r, r_tilt_p;
    logic r_zero;

    logic signed [16:0] op_a, op_b;
    logic [33:0] sq_a, sq_b;
    logic signed [16:0] sel_a, sel_b;

    always_comb begin
        sel_a = i_cmd.sel ? 17'(r_ay) : 17'(r_ax);
        sel_b = 17'(r_az);
        op_a = sel_a;
        op_b = sel_b;
        sq_a = 34'(op_a * op_a);
        sq_b = 34'(op_b * op_b);
    end

    logic [33:0] trial;
    logic [33:0] rem_sh;
    always_comb begin
        rem_sh = {r_rem[31:0], r_rem_n[63:62]};
        trial = rem_sh - {r_root, 2'b01};
    end

    // CORDIC step
    logic signed [XW-1:0] dx, dy;
    always_comb begin
        dx = r_y >>> r_cnt;
        dy = r_x >>> r_cnt;
    end

    // Shared 34x25 signed multiplier (operands chosen per op), registered product.
    logic signed [33:0] m_a;
    logic signed [24:0] m_b;
    logic signed [58:0] m_p;
    logic signed [58:0] r_prod;
    logic [17:0] alpha, beta;
    logic signed [33:0] r_inc_x, r_inc_y, r_inc_z;
    logic signed [33:0] g_r, g_p;
    logic signed [31:0] r_roll, r_pitch, r_yaw;
    logic signed [63:0] r_acc;
    logic [3:0] r_op_d;
    logic r_mul_d;

    assign alpha = (i_blend_weight > 17'd65536) ? 18'd65536 : {1'b0, i_blend_weight};
    assign beta = 18'd65536 - alpha;
    assign g_r = 34'(r_roll) + r_inc_x;
    assign g_p = 34'(r_pitch) + r_inc_y;

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (i_cmd.mul_op)
            MulIncX:   begin m_a = 34'(r_gx); m_b = {1'b0, i_gyro_gain}; end
            MulIncY:   begin m_a = 34'(r_gy); m_b = {1'b0, i_gyro_gain}; end
            MulIncZ:   begin m_a = 34'(r_gz); m_b = {1'b0, i_gyro_gain}; end
            MulRollG:  begin m_a = g_r; m_b = 25'(alpha); end
            MulRollT:  begin m_a = 34'(r_tilt_r); m_b = 25'(beta); end
            MulPitchG: begin m_a = g_p; m_b = 25'(alpha); end
            MulPitchT: begin m_a = 34'(r_tilt_p); m_b = 25'(beta); end
            default:   begin m_a = '0; m_b = '0; end
        endcase
        m_p = 59'(m_a) * 59'(m_b);
    end

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'h7FFFFFFF;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    logic signed [58:0] inc_rnd;
    logic signed [63:0] acc_sum, blend_v;
    logic signed [ZW-1:0] z_rnd;
    assign inc_rnd = (r_prod + (59'sd1 <<< (GSh - 1))) >>> GSh;
    assign acc_sum = r_acc + 64'(r_prod);
    assign blend_v = (acc_sum + 64'sd32768) >>> 16;
    assign z_rnd = (r_z + (ZW'(1) <<< (ZSh - 1))) >>> ZSh;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax <= i_ax; r_ay <= i_ay; r_az <= i_az;
            r_gx <= i_gx; r_gy <= i_gy; r_gz <= i_gz;
        end
        if (i_cmd.sq_start) begin
            r_sq <= 32'(sq_a + sq_b);
            r_rem_n <= {32'(sq_a + sq_b), 32'd0};
            r_rem <= '0;
            r_root <= '0;
            r_cnt <= '0;
            r_num <= i_cmd.sel ? -17'(r_ax) : 17'(r_ay);
        end
        if (i_cmd.sq_step) begin
            r_rem_n <= {r_rem_n[61:0], 2'b00};
            if (!trial[33]) begin
                r_rem <= trial;
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_root <= {r_root[30:0], 1'b0};
            end
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.cor_init) begin
            r_x <= XW'({8'd0, r_root});
            r_y <= XW'(r_num) <<< 16;
            r_z <= '0;
            r_cnt <= '0;
            r_zero <= (r_sq == 32'd0) && (r_num == 17'sd0);
        end
        if (i_cmd.cor_step) begin
            if (r_y < 0) begin
                r_x <= r_x - dx; r_y <= r_y + dy; r_z <= r_z - atan_deg(r_cnt);
            end else begin
                r_x <= r_x + dx; r_y <= r_y - dy; r_z <= r_z + atan_deg(r_cnt);
            end
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.tilt_save) begin
            if (i_cmd.sel) r_tilt_p <= r_zero ? '0 : 32'(z_rnd);
            else r_tilt_r <= r_zero ? '0 : 32'(z_rnd);
        end
        r_mul_d <= i_cmd.mul_en;
        r_op_d <= i_cmd.mul_op;
        if (i_cmd.mul_en) r_prod <= m_p;
        // Consume the previous product.
        if (r_mul_d) begin
            case (r_op_d)
                MulIncX:   r_inc_x <= 34'(inc_rnd);
                MulIncY:   r_inc_y <= 34'(inc_rnd);
                MulIncZ:   r_inc_z <= 34'(inc_rnd);
                MulRollG:  r_acc <= 64'(r_prod);
                MulRollT:  r_roll <= sat32(blend_v);
                MulPitchG: r_acc <= 64'(r_prod);
                MulPitchT: r_pitch <= sat32(blend_v);
                default:   r_acc <= r_acc;
            endcase
        end
        if (i_cmd.commit) begin
            r_yaw <= sat32(64'(r_yaw) + 64'(r_inc_z));
            o_roll <= r_roll;
            o_pitch <= r_pitch;
            o_yaw <= sat32(64'(r_yaw) + 64'(r_inc_z));
        end
        if (!i_rst_n) begin
            r_roll <= '0;
            r_pitch <= '0;
            r_yaw <= '0;
        end
    end

    assign o_sts.sq_done = (r_cnt == CntW'(31));
    assign o_sts.cor_done = (r_cnt == CntW'(Steps - 1));
endmodule

// ===== sv/tilt_complementary_filter_core.sv =====
// Tilt complementary filter: roll/pitch blend of gyro and accelerometer tilt, yaw integration.
// Each sample runs the square root and CORDIC for the roll tilt, then for the pitch tilt,
// then the shared multiply sequence before the result is registered. A new sample is taken
// only once the last is done: the input stalls until the result is registered, and an output
// stall holds the finished sample until the earlier result has been taken.
// Synchronous active-low reset clears angles and restores register defaults.
module tilt_complementary_filter_core #(
    parameter int unsigned CORDIC_STEPS    = 16,
    parameter int unsigned ANGLE_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_accel_x_sample,
    input  logic signed [15:0] i_accel_y_sample,
    input  logic signed [15:0] i_accel_z_sample,
    input  logic signed [15:0] i_rate_x_sample,
    input  logic signed [15:0] i_rate_y_sample,
    input  logic signed [15:0] i_rate_z_sample,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_roll_out,
    output logic signed [31:0] o_pitch_out,
    output logic signed [31:0] o_yaw_out
);
    import tcf_pkg::*;

    localparam logic [2:0] AddrBlend = 3'd0;
    localparam logic [2:0] AddrGain  = 3'd4;

    logic [16:0] r_blend_weight;
    logic [23:0] r_gyro_gain;
    t_cmd cmd;
    t_sts sts;

    // Register file: written on the access phase of an APB write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_weight <= 17'd62259;
            r_gyro_gain <= 24'd32786;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                AddrBlend: r_blend_weight <= pwdata[16:0];
                AddrGain:  r_gyro_gain <= pwdata[23:0];
                default:   r_gyro_gain <= r_gyro_gain;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            AddrBlend: prdata = {15'd0, r_blend_weight};
            AddrGain:  prdata = {8'd0, r_gyro_gain};
            default:   prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    tcf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .o_in_stall(o_stall),
        .o_out_valid(o_valid), .i_out_stall(i_stall),
        .o_cmd(cmd), .i_sts(sts)
    );

    tcf_datapath #(
        .CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .o_sts(sts), .i_rst_n(i_rst_n),
        .i_ax(i_accel_x_sample), .i_ay(i_accel_y_sample), .i_az(i_accel_z_sample),
        .i_gx(i_rate_x_sample), .i_gy(i_rate_y_sample), .i_gz(i_rate_z_sample),
        .i_blend_weight(r_blend_weight), .i_gyro_gain(r_gyro_gain),
        .o_roll(o_roll_out), .o_pitch(o_pitch_out), .o_yaw(o_yaw_out)
    );
endmodule
